FILE: sv/isor_pkg.sv
// Shared types, constants and codes for the indexed sprite outline render unit.
`default_nettype none
package isor_pkg;

   // default sizing of the top level
   localparam int DEF_MAX_WIDTH  = 128;
   localparam int DEF_MAX_HEIGHT = 128;
   localparam int DEF_MAX_BORDER = 15;

   // palette geometry
   localparam int PAL_DEPTH = 256;
   localparam int PAL_AW    = 8;

   // alpha codes
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
   localparam logic [7:0] COLOR_MAX    = 8'hFF;

   // register reset values
   localparam logic [7:0]  RST_IMAGE_WIDTH  = 8'd1;
   localparam logic [7:0]  RST_IMAGE_HEIGHT = 8'd1;
   localparam logic [3:0]  RST_BORDER_SIZE  = 4'd0;
   localparam logic [15:0] RST_GAIN_Q8      = 16'd256;
   localparam logic [7:0]  RST_FILL_RED     = 8'd0;
   localparam logic [7:0]  RST_FILL_GREEN   = 8'd255;
   localparam logic [7:0]  RST_FILL_BLUE    = 8'd0;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_BORDER_SIZE  = 3'd2,
      REG_GAIN_Q8      = 3'd3,
      REG_FILL_RED     = 3'd4,
      REG_FILL_GREEN   = 3'd5,
      REG_FILL_BLUE    = 3'd6
   } csr_index_type;

   // item opcodes
   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   // frame fetch slots, in evaluation order
   typedef enum logic [2:0] {
      SLOT_CENTER = 3'd0,
      SLOT_UP     = 3'd1,
      SLOT_DOWN   = 3'd2,
      SLOT_LEFT   = 3'd3,
      SLOT_RIGHT  = 3'd4
   } slot_type;

   // result source
   typedef enum logic [1:0] {
      EMIT_BORDER = 2'd0,
      EMIT_CLEAR  = 2'd1,
      EMIT_COLOR  = 2'd2
   } emit_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CALC,
      ST_WRITE,
      ST_FETCH,
      ST_LAST,
      ST_PAL,
      ST_SCALE,
      ST_EMIT_BORDER,
      ST_EMIT_CLEAR,
      ST_EMIT_COLOR
   } state_type;

   // configuration register set
   typedef struct packed {
      logic [7:0]  image_width;
      logic [7:0]  image_height;
      logic [3:0]  border_size;
      logic [15:0] gain_q8;
      logic [7:0]  fill_red;
      logic [7:0]  fill_green;
      logic [7:0]  fill_blue;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic     accept;
      logic     calc;
      logic     pal_we;
      logic     frame_we;
      logic     fetch;
      slot_type slot;
      logic     pal_re;
      logic     scale;
      logic     load;
      emit_type sel;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      opcode_type op;
      logic       border;
      logic       write_ok;
      logic       center_hit;
      logic       found_next;
      logic       out_free;
   } sts_type;

endpackage
`default_nettype wire

FILE: sv/isor_csr.sv
// Configuration register file of the render unit.
`default_nettype none
module isor_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [2:0]       csr_index,
   input  wire logic [15:0]      csr_data,
   output isor_pkg::cfg_type     cfg
);

   isor_pkg::cfg_type cfg_ff;
   isor_pkg::cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (isor_pkg::csr_index_type'(csr_index))
            isor_pkg::REG_IMAGE_WIDTH:  cfg_in.image_width  = csr_data[7:0];
            isor_pkg::REG_IMAGE_HEIGHT: cfg_in.image_height = csr_data[7:0];
            isor_pkg::REG_BORDER_SIZE:  cfg_in.border_size  = csr_data[3:0];
            isor_pkg::REG_GAIN_Q8:      cfg_in.gain_q8      = csr_data;
            isor_pkg::REG_FILL_RED:     cfg_in.fill_red     = csr_data[7:0];
            isor_pkg::REG_FILL_GREEN:   cfg_in.fill_green   = csr_data[7:0];
            isor_pkg::REG_FILL_BLUE:    cfg_in.fill_blue    = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= isor_pkg::RST_IMAGE_WIDTH;
         cfg_ff.image_height <= isor_pkg::RST_IMAGE_HEIGHT;
         cfg_ff.border_size  <= isor_pkg::RST_BORDER_SIZE;
         cfg_ff.gain_q8      <= isor_pkg::RST_GAIN_Q8;
         cfg_ff.fill_red     <= isor_pkg::RST_FILL_RED;
         cfg_ff.fill_green   <= isor_pkg::RST_FILL_GREEN;
         cfg_ff.fill_blue    <= isor_pkg::RST_FILL_BLUE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/isor_ctrl.sv
// Sequencing state machine of the render unit.
`default_nettype none
module isor_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire isor_pkg::sts_type sts,
   output isor_pkg::cmd_type      cmd
);

   isor_pkg::state_type state_ff, state_in;
   isor_pkg::slot_type  slot_ff, slot_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isor_pkg::ST_IDLE;
         slot_ff  <= isor_pkg::SLOT_CENTER;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         isor_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = isor_pkg::ST_CALC;
            end
         end
         isor_pkg::ST_CALC: begin
            cmd.calc = 1'b1;
            unique case (sts.op)
               isor_pkg::OP_LOAD: begin
                  cmd.pal_we = 1'b1;
                  state_in   = isor_pkg::ST_IDLE;
               end
               isor_pkg::OP_WRITE: begin
                  state_in = sts.write_ok ? isor_pkg::ST_WRITE : isor_pkg::ST_IDLE;
               end
               isor_pkg::OP_READ: begin
                  if (sts.border) begin
                     state_in = isor_pkg::ST_EMIT_BORDER;
                  end else begin
                     slot_in  = isor_pkg::SLOT_CENTER;
                     state_in = isor_pkg::ST_FETCH;
                  end
               end
               default: state_in = isor_pkg::ST_IDLE;
            endcase
         end
         isor_pkg::ST_WRITE: begin
            cmd.frame_we = 1'b1;
            state_in     = isor_pkg::ST_IDLE;
         end
         // one frame read a cycle, the previous read is judged meanwhile
         isor_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
            cmd.slot  = slot_ff;
            if (sts.center_hit) begin
               state_in = isor_pkg::ST_PAL;
            end else begin
               unique case (slot_ff)
                  isor_pkg::SLOT_CENTER: slot_in = isor_pkg::SLOT_UP;
                  isor_pkg::SLOT_UP:     slot_in = isor_pkg::SLOT_DOWN;
                  isor_pkg::SLOT_DOWN:   slot_in = isor_pkg::SLOT_LEFT;
                  isor_pkg::SLOT_LEFT:   slot_in = isor_pkg::SLOT_RIGHT;
                  default:               state_in = isor_pkg::ST_LAST;
               endcase
            end
         end
         isor_pkg::ST_LAST: begin
            state_in = sts.found_next ? isor_pkg::ST_PAL : isor_pkg::ST_EMIT_CLEAR;
         end
         isor_pkg::ST_PAL: begin
            cmd.pal_re = 1'b1;
            state_in   = isor_pkg::ST_SCALE;
         end
         isor_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = isor_pkg::ST_EMIT_COLOR;
         end
         isor_pkg::ST_EMIT_BORDER: begin
            cmd.sel = isor_pkg::EMIT_BORDER;
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = isor_pkg::ST_IDLE;
            end
         end
         isor_pkg::ST_EMIT_CLEAR: begin
            cmd.sel = isor_pkg::EMIT_CLEAR;
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = isor_pkg::ST_IDLE;
            end
         end
         isor_pkg::ST_EMIT_COLOR: begin
            cmd.sel = isor_pkg::EMIT_COLOR;
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = isor_pkg::ST_IDLE;
            end
         end
         default: state_in = isor_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

FILE: sv/isor_dp.sv
// Datapath of the render unit: item latch, frame and palette memories, scaling, output.
`default_nettype none
module isor_dp #(
   parameter int MAX_WIDTH  = isor_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = isor_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_BORDER = isor_pkg::DEF_MAX_BORDER
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire isor_pkg::cfg_type  cfg,
   input  wire isor_pkg::cmd_type  cmd,
   output isor_pkg::sts_type       sts,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [7:0]         req_color_index,
   input  wire logic [7:0]         req_entry_red,
   input  wire logic [7:0]         req_entry_green,
   input  wire logic [7:0]         req_entry_blue,
   input  wire logic [7:0]         req_column,
   input  wire logic [7:0]         req_line,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_out_red,
   output logic [7:0]              rsp_out_green,
   output logic [7:0]              rsp_out_blue,
   output logic [7:0]              rsp_out_alpha
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int BW    = $clog2(MAX_BORDER + 2);
   localparam int SW0   = (WW > HW) ? WW : HW;
   localparam int SW1   = (SW0 > BW) ? SW0 : BW;
   localparam int CW    = (SW1 + 1 > 8) ? SW1 + 1 : 8;
   localparam int PW    = WW + HW + 1;
   localparam int NW    = AW + WW;

   // latched item
   isor_pkg::opcode_type op_ff;
   logic [7:0]  ci_ff, red_ff, green_ff, blue_ff, col_ff, lin_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= isor_pkg::opcode_type'(req_opcode);
         ci_ff    <= req_color_index;
         red_ff   <= req_entry_red;
         green_ff <= req_entry_green;
         blue_ff  <= req_entry_blue;
         col_ff   <= req_column;
         lin_ff   <= req_line;
      end
   end

   // effective sizes, clipped to the build limits
   logic [CW-1:0] w_raw, h_raw, b_raw, w_e, h_e, b_e;
   logic [WW-1:0] w_n;

   always_comb begin
      w_raw = CW'(cfg.image_width);
      h_raw = CW'(cfg.image_height);
      b_raw = CW'(cfg.border_size);
      w_e   = (w_raw > CW'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : w_raw;
      h_e   = (h_raw > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : h_raw;
      b_e   = (b_raw > CW'(MAX_BORDER)) ? CW'(MAX_BORDER) : b_raw;
      w_n   = w_e[WW-1:0];
   end

   // coordinate checks and base address
   logic [CW-1:0] colw, linw, colr, linr;
   logic [WW-1:0] xs;
   logic [HW-1:0] ys;
   logic [PW-1:0] base_sum;
   logic          border, write_ok;

   always_comb begin
      colw     = CW'(col_ff);
      linw     = CW'(lin_ff);
      colr     = colw - b_e;
      linr     = linw - b_e;
      border   = (colw < b_e) || (linw < b_e) ||
                 (colw >= w_e + b_e) || (linw >= h_e + b_e);
      write_ok = (colw < w_e) && (linw < h_e);
      if (op_ff == isor_pkg::OP_READ) begin
         xs = colr[WW-1:0];
         ys = linr[HW-1:0];
      end else begin
         xs = colw[WW-1:0];
         ys = linw[HW-1:0];
      end
      base_sum = PW'(ys * w_n) + PW'(xs);
   end

   logic [AW-1:0] base_ff;
   logic [WW-1:0] x_ff;
   logic [HW-1:0] y_ff;

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         base_ff <= base_sum[AW-1:0];
         x_ff    <= xs;
         y_ff    <= ys;
      end
   end

   // neighbor addresses and bounds
   logic [NW-1:0] base_x, w_x, up_x, down_x, left_x, right_x;
   logic [CW-1:0] x_next, y_next;
   logic          up_ok, down_ok, left_ok, right_ok;

   always_comb begin
      base_x   = NW'(base_ff);
      w_x      = NW'(w_n);
      up_x     = base_x - w_x;
      down_x   = base_x + w_x;
      left_x   = base_x - NW'(1);
      right_x  = base_x + NW'(1);
      x_next   = CW'(x_ff) + CW'(1);
      y_next   = CW'(y_ff) + CW'(1);
      up_ok    = (y_ff != '0);
      down_ok  = (y_next < h_e);
      left_ok  = (x_ff != '0);
      right_ok = (x_next < w_e);
   end

   // fetch address select
   logic [AW-1:0] raddr;
   logic          slot_ok;

   always_comb begin
      raddr   = base_ff;
      slot_ok = 1'b0;
      unique case (cmd.slot)
         isor_pkg::SLOT_CENTER: begin raddr = base_ff;            slot_ok = 1'b1;     end
         isor_pkg::SLOT_UP:     begin raddr = up_x[AW-1:0];       slot_ok = up_ok;    end
         isor_pkg::SLOT_DOWN:   begin raddr = down_x[AW-1:0];     slot_ok = down_ok;  end
         isor_pkg::SLOT_LEFT:   begin raddr = left_x[AW-1:0];     slot_ok = left_ok;  end
         isor_pkg::SLOT_RIGHT:  begin raddr = right_x[AW-1:0];    slot_ok = right_ok; end
         default:               begin raddr = base_ff;            slot_ok = 1'b0;     end
      endcase
   end

   // frame memory, one port
   logic [7:0] frame_mem [DEPTH];
   logic [7:0] frame_rd_ff;
   logic       frame_re;

   assign frame_re = cmd.fetch && slot_ok;

   always_ff @(posedge clock) begin
      if (cmd.frame_we) begin
         frame_mem[base_ff] <= ci_ff;
      end
      if (frame_re) begin
         frame_rd_ff <= frame_mem[raddr];
      end
   end

   // slot tag of the read in flight
   isor_pkg::slot_type tag_ff;
   logic               tag_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_vld_ff <= 1'b0;
      end else begin
         tag_vld_ff <= frame_re;
      end
      tag_ff <= cmd.slot;
   end

   // pick: center wins outright, else the last opaque neighbor
   logic       ctr_hit, nbr_hit, center_hit_ff, found_ff;
   logic [7:0] pick_ff;

   always_comb begin
      ctr_hit = tag_vld_ff && (tag_ff == isor_pkg::SLOT_CENTER) && (frame_rd_ff != '0);
      nbr_hit = tag_vld_ff && (tag_ff != isor_pkg::SLOT_CENTER) && !center_hit_ff &&
                (frame_rd_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.calc) begin
         center_hit_ff <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         if (ctr_hit) begin
            center_hit_ff <= 1'b1;
         end
         if (ctr_hit || nbr_hit) begin
            found_ff <= 1'b1;
         end
      end
      if (ctr_hit || nbr_hit) begin
         pick_ff <= frame_rd_ff;
      end
   end

   // palette memory
   logic [23:0] pal_mem [isor_pkg::PAL_DEPTH];
   logic [23:0] pal_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.pal_we) begin
         pal_mem[ci_ff] <= {red_ff, green_ff, blue_ff};
      end
      if (cmd.pal_re) begin
         pal_rd_ff <= pal_mem[pick_ff];
      end
   end

   // gain scaling with saturation
   logic [23:0] prod_r, prod_g, prod_b;
   logic [7:0]  sc_r, sc_g, sc_b;
   logic [7:0]  sc_r_ff, sc_g_ff, sc_b_ff;

   always_comb begin
      prod_r = pal_rd_ff[23:16] * cfg.gain_q8;
      prod_g = pal_rd_ff[15:8]  * cfg.gain_q8;
      prod_b = pal_rd_ff[7:0]   * cfg.gain_q8;
      sc_r   = (prod_r[23:16] != '0) ? isor_pkg::COLOR_MAX : prod_r[15:8];
      sc_g   = (prod_g[23:16] != '0) ? isor_pkg::COLOR_MAX : prod_g[15:8];
      sc_b   = (prod_b[23:16] != '0) ? isor_pkg::COLOR_MAX : prod_b[15:8];
   end

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         sc_r_ff <= sc_r;
         sc_g_ff <= sc_g;
         sc_b_ff <= sc_b;
      end
   end

   // output register
   logic       rsp_valid_ff;
   logic [7:0] o_r_ff, o_g_ff, o_b_ff, o_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load) begin
         unique case (cmd.sel)
            isor_pkg::EMIT_COLOR: begin
               o_r_ff <= sc_r_ff;
               o_g_ff <= sc_g_ff;
               o_b_ff <= sc_b_ff;
               o_a_ff <= isor_pkg::ALPHA_OPAQUE;
            end
            isor_pkg::EMIT_CLEAR: begin
               o_r_ff <= cfg.fill_red;
               o_g_ff <= cfg.fill_green;
               o_b_ff <= cfg.fill_blue;
               o_a_ff <= isor_pkg::ALPHA_CLEAR;
            end
            default: begin
               o_r_ff <= cfg.fill_red;
               o_g_ff <= cfg.fill_green;
               o_b_ff <= cfg.fill_blue;
               o_a_ff <= isor_pkg::ALPHA_OPAQUE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = o_r_ff;
   assign rsp_out_green = o_g_ff;
   assign rsp_out_blue  = o_b_ff;
   assign rsp_out_alpha = o_a_ff;

   // status
   always_comb begin
      sts.op         = op_ff;
      sts.border     = border;
      sts.write_ok   = write_ok;
      sts.center_hit = ctr_hit;
      sts.found_next = found_ff || ctr_hit || nbr_hit;
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

endmodule
`default_nettype wire

FILE: sv/indexed_sprite_outline_render_unit.sv
// Top level of the indexed sprite outline render unit.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   opcode, color_index, entry_*, column, line
//   rsp_      out        rsp_valid/rsp_stall   out_red, out_green, out_blue, out_alpha
//   csr_      in         csr_valid/csr_ready   csr_index, csr_data
//
// One item at a time: a palette load, a pixel write, a border read, or a read
// of an opaque or a transparent pixel; a transparent pixel may take the fill
// color. Reads are paced by the single-port frame memory, which returns center
// then up, down, left, right, one per cycle. A finished result sits in the
// output register while the next item is taken; a stalled result holds the
// next read in its emit step. Reset is synchronous; frame and palette contents
// are not cleared.
`default_nettype none
module indexed_sprite_outline_render_unit #(
   parameter int MAX_WIDTH  = isor_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = isor_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_BORDER = isor_pkg::DEF_MAX_BORDER
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [7:0]  req_color_index,
   input  wire logic [7:0]  req_entry_red,
   input  wire logic [7:0]  req_entry_green,
   input  wire logic [7:0]  req_entry_blue,
   input  wire logic [7:0]  req_column,
   input  wire logic [7:0]  req_line,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_red,
   output logic [7:0]       rsp_out_green,
   output logic [7:0]       rsp_out_blue,
   output logic [7:0]       rsp_out_alpha,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   isor_pkg::cfg_type cfg;
   isor_pkg::cmd_type cmd;
   isor_pkg::sts_type sts;

   isor_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   isor_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   isor_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_BORDER (MAX_BORDER)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .sts             (sts),
      .req_opcode      (req_opcode),
      .req_color_index (req_color_index),
      .req_entry_red   (req_entry_red),
      .req_entry_green (req_entry_green),
      .req_entry_blue  (req_entry_blue),
      .req_column      (req_column),
      .req_line        (req_line),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_out_alpha   (rsp_out_alpha)
   );

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the indexed sprite outline render unit.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

   localparam int FRAME_DEPTH = isor_pkg::DEF_MAX_WIDTH * isor_pkg::DEF_MAX_HEIGHT;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_type;

   // block ports, all inputs known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = isor_pkg::OP_NONE;
   logic [7:0]  req_color_index = 8'h00;
   logic [7:0]  req_entry_red = 8'h00;
   logic [7:0]  req_entry_green = 8'h00;
   logic [7:0]  req_entry_blue = 8'h00;
   logic [7:0]  req_column = 8'h00;
   logic [7:0]  req_line = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic [7:0]  rsp_out_alpha;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = isor_pkg::REG_IMAGE_WIDTH;
   logic [15:0] csr_data = 16'h0000;

   // predictor state: register copy, palette and frame with written flags
   isor_pkg::cfg_type cfg_shadow;
   logic [7:0]  pal_red [isor_pkg::PAL_DEPTH];
   logic [7:0]  pal_green [isor_pkg::PAL_DEPTH];
   logic [7:0]  pal_blue [isor_pkg::PAL_DEPTH];
   bit          pal_written [isor_pkg::PAL_DEPTH];
   logic [7:0]  opaque_indexes [$];
   logic [7:0]  frame_store [FRAME_DEPTH];
   bit          frame_written [FRAME_DEPTH];

   pixel_type   pending_pixels [$];
   int          mismatch_count = 0;
   int          send_gap_pct = 20;
   int          stall_pct = 20;

   indexed_sprite_outline_render_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_color_index (req_color_index),
      .req_entry_red   (req_entry_red),
      .req_entry_green (req_entry_green),
      .req_entry_blue  (req_entry_blue),
      .req_column      (req_column),
      .req_line        (req_line),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_out_alpha   (rsp_out_alpha),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // effective sizes after saturation
   function automatic int eff_width();
      return (cfg_shadow.image_width > isor_pkg::DEF_MAX_WIDTH) ? isor_pkg::DEF_MAX_WIDTH
                                                                : cfg_shadow.image_width;
   endfunction

   function automatic int eff_height();
      return (cfg_shadow.image_height > isor_pkg::DEF_MAX_HEIGHT) ? isor_pkg::DEF_MAX_HEIGHT
                                                                  : cfg_shadow.image_height;
   endfunction

   function automatic int eff_border();
      return (cfg_shadow.border_size > isor_pkg::DEF_MAX_BORDER) ? isor_pkg::DEF_MAX_BORDER
                                                                 : cfg_shadow.border_size;
   endfunction

   // component times 8.8 gain, truncated, clipped at full scale
   function automatic logic [7:0] scale_component(logic [7:0] c);
      logic [23:0] prod;
      prod = {16'h0000, c} * {8'h00, cfg_shadow.gain_q8};
      return (prod[23:8] > isor_pkg::COLOR_MAX) ? isor_pkg::COLOR_MAX : prod[15:8];
   endfunction

   // Expected pixel at a canvas position. Returns 0 when the answer would
   // depend on a palette or frame entry that was never written.
   function automatic bit render_pixel(input logic [7:0] col, lin, output pixel_type px);
      int w, h, b, x, y, nx, ny, addr;
      int dx [4] = '{0, 0, -1, 1};
      int dy [4] = '{-1, 1, 0, 0};
      logic [7:0] pick;
      w = eff_width();
      h = eff_height();
      b = eff_border();
      px = {cfg_shadow.fill_red, cfg_shadow.fill_green, cfg_shadow.fill_blue,
            isor_pkg::ALPHA_OPAQUE};
      if (col < b || lin < b || col >= w + b || lin >= h + b) return 1'b1;
      x = col - b;
      y = lin - b;
      addr = y * w + x;
      if (!frame_written[addr]) return 1'b0;
      pick = frame_store[addr];
      // transparent: scan above, below, left, right; last opaque one wins
      if (pick == 8'h00) begin
         for (int k = 0; k < 4; k++) begin
            nx = x + dx[k];
            ny = y + dy[k];
            if (nx >= 0 && nx < w && ny >= 0 && ny < h) begin
               addr = ny * w + nx;
               if (!frame_written[addr]) return 1'b0;
               if (frame_store[addr] != 8'h00) pick = frame_store[addr];
            end
         end
      end
      if (pick == 8'h00) begin
         px.alpha = isor_pkg::ALPHA_CLEAR;
         return 1'b1;
      end
      if (!pal_written[pick]) return 1'b0;
      px = {scale_component(pal_red[pick]), scale_component(pal_green[pick]),
            scale_component(pal_blue[pick]), isor_pkg::ALPHA_OPAQUE};
      return 1'b1;
   endfunction

   function automatic logic [7:0] any_opaque_index();
      return opaque_indexes[$urandom_range(0, opaque_indexes.size() - 1)];
   endfunction

   // send one item; update the predictor when it is taken
   task automatic send_item(isor_pkg::opcode_type op, logic [7:0] idx, red, green, blue,
                            col, lin);
      int addr;
      pixel_type px;
      @(negedge clock);
      if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_opcode      <= op;
      req_color_index <= idx;
      req_entry_red   <= red;
      req_entry_green <= green;
      req_entry_blue  <= blue;
      req_column      <= col;
      req_line        <= lin;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (op)
         isor_pkg::OP_LOAD: begin
            pal_red[idx]   = red;
            pal_green[idx] = green;
            pal_blue[idx]  = blue;
            if (!pal_written[idx]) begin
               pal_written[idx] = 1'b1;
               if (idx != 8'h00) opaque_indexes.push_back(idx);
            end
         end
         isor_pkg::OP_WRITE: begin
            if (col < eff_width() && lin < eff_height()) begin
               addr = lin * eff_width() + col;
               frame_store[addr]   = idx;
               frame_written[addr] = 1'b1;
            end
         end
         isor_pkg::OP_READ: begin
            void'(render_pixel(col, lin, px));
            pending_pixels.push_back(px);
         end
         default: ;
      endcase
   endtask

   // drop valid, wait for all pixels, then let a write in flight finish
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(isor_pkg::csr_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         isor_pkg::REG_IMAGE_WIDTH:  cfg_shadow.image_width  = value[7:0];
         isor_pkg::REG_IMAGE_HEIGHT: cfg_shadow.image_height = value[7:0];
         isor_pkg::REG_BORDER_SIZE:  cfg_shadow.border_size  = value[3:0];
         isor_pkg::REG_GAIN_Q8:      cfg_shadow.gain_q8      = value;
         isor_pkg::REG_FILL_RED:     cfg_shadow.fill_red     = value[7:0];
         isor_pkg::REG_FILL_GREEN:   cfg_shadow.fill_green   = value[7:0];
         isor_pkg::REG_FILL_BLUE:    cfg_shadow.fill_blue    = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_config(logic [7:0] w, h, logic [3:0] b, logic [15:0] gain,
                               logic [7:0] fr, fg, fb);
      wait_idle();
      write_csr(isor_pkg::REG_IMAGE_WIDTH,  {8'h00, w});
      write_csr(isor_pkg::REG_IMAGE_HEIGHT, {8'h00, h});
      write_csr(isor_pkg::REG_BORDER_SIZE,  {12'h000, b});
      write_csr(isor_pkg::REG_GAIN_Q8,      gain);
      write_csr(isor_pkg::REG_FILL_RED,     {8'h00, fr});
      write_csr(isor_pkg::REG_FILL_GREEN,   {8'h00, fg});
      write_csr(isor_pkg::REG_FILL_BLUE,    {8'h00, fb});
   endtask

   // paint the top-left window of the image, about 40% transparent
   task automatic fill_window();
      logic [7:0] idx;
      for (int y = 0; y < ((eff_height() < 8) ? eff_height() : 8); y++) begin
         for (int x = 0; x < ((eff_width() < 12) ? eff_width() : 12); x++) begin
            idx = ($urandom_range(0, 9) < 4) ? 8'h00 : any_opaque_index();
            send_item(isor_pkg::OP_WRITE, idx, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'(x), 8'(y));
         end
      end
   endtask

   // one random item: mostly reads that land on written pixels
   task automatic random_item();
      int roll, w, h, b, hot_w, hot_h;
      bit ok;
      logic [7:0] col, lin, idx;
      pixel_type px;
      w = eff_width();
      h = eff_height();
      b = eff_border();
      hot_w = (w < 12) ? w : 12;
      hot_h = (h < 8) ? h : 8;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         ok = 1'b0;
         for (int tries = 0; tries < 8 && !ok; tries++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  col = 8'(b + $urandom_range(0, hot_w));
                  lin = 8'(b + $urandom_range(0, hot_h));
               end
               5, 6, 7: begin
                  col = 8'($urandom_range(0, w + 2 * b));
                  lin = 8'($urandom_range(0, h + 2 * b));
               end
               default: begin
                  col = 8'($urandom);
                  lin = 8'($urandom);
               end
            endcase
            ok = render_pixel(col, lin, px);
         end
         // far right of any canvas is always border
         if (!ok) col = 8'hFF;
         send_item(isor_pkg::OP_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), col, lin);
      end else if (roll < 75) begin
         if ($urandom_range(0, 4) == 0) begin
            col = 8'($urandom);
            lin = 8'($urandom);
         end else begin
            col = 8'($urandom_range(0, hot_w));
            lin = 8'($urandom_range(0, hot_h));
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: idx = 8'h00;
            4:          idx = 8'($urandom);
            default:    idx = any_opaque_index();
         endcase
         send_item(isor_pkg::OP_WRITE, idx, 8'($urandom), 8'($urandom), 8'($urandom),
                   col, lin);
      end else if (roll < 95) begin
         send_item(isor_pkg::OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
         send_item(isor_pkg::OP_NONE, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic run_phase(logic [7:0] w, h, logic [3:0] b, logic [15:0] gain,
                            logic [7:0] fr, fg, fb, int count);
      apply_config(w, h, b, gain, fr, fg, fb);
      fill_window();
      for (int i = 0; i < count; i++) begin
         // halfway, hold off until every pixel is back
         if (i == count / 2) wait_idle();
         random_item();
      end
   endtask

   // reset sizes 1x1: opaque, border, transparent with no neighbor, ignored items
   task automatic test_reset_values();
      send_item(isor_pkg::OP_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00);
      send_item(isor_pkg::OP_LOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(isor_pkg::OP_WRITE, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(isor_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(isor_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00);
      send_item(isor_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF);
      send_item(isor_pkg::OP_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(isor_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(isor_pkg::OP_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      // outside the image, must not land
      send_item(isor_pkg::OP_WRITE, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00);
      send_item(isor_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
   endtask

   // 3x3 with border, saturating gain, neighbor priority and clear fill
   task automatic test_gain_and_neighbors();
      logic [7:0] idx;
      apply_config(8'd3, 8'd3, 4'd1, 16'hFFFF, 8'd170, 8'd85, 8'd15);
      send_item(isor_pkg::OP_LOAD, 8'h01, 8'h00, 8'h01, 8'h80, 8'h00, 8'h00);
      send_item(isor_pkg::OP_LOAD, 8'h02, 8'hFF, 8'h80, 8'h03, 8'h00, 8'h00);
      for (int y = 0; y < 3; y++) begin
         for (int x = 0; x < 3; x++) begin
            idx = (x == 1 && y == 0) ? 8'h01 : ((x == 2 && y == 1) ? 8'h02 : 8'h00);
            send_item(isor_pkg::OP_WRITE, idx, 8'h00, 8'h00, 8'h00, 8'(x), 8'(y));
         end
      end
      send_item(isor_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'd2, 8'd2);
      send_item(isor_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'd1, 8'd1);
      send_item(isor_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'd1, 8'd3);
      send_item(isor_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'd2, 8'd1);
      send_item(isor_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0);
   endtask

   // frame contents stay put when the width changes
   task automatic test_resize_reuse();
      apply_config(8'd3, 8'd2, 4'd0, 16'd300, 8'd255, 8'd0, 8'd255);
      fill_window();
      apply_config(8'd2, 8'd3, 4'd0, 16'd300, 8'd255, 8'd0, 8'd255);
      for (int y = 0; y < 3; y++)
         for (int x = 0; x < 2; x++)
            send_item(isor_pkg::OP_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'(x), 8'(y));
   endtask

   task automatic test_random_sizes();
      send_gap_pct = 15;
      stall_pct = 15;
      run_phase(8'd8, 8'd8, 4'd2, 16'd256, 8'd0, 8'd0, 8'd255, 180);
      send_gap_pct = 0;
      stall_pct = 25;
      run_phase(8'd5, 8'd3, 4'd0, 16'hFFFF, 8'd255, 8'd0, 8'd0, 120);
      send_gap_pct = 30;
      stall_pct = 0;
      run_phase(8'd1, 8'd1, 4'd15, 16'd0, 8'd0, 8'd0, 8'd0, 80);
      send_gap_pct = 10;
      stall_pct = 10;
      run_phase(8'd200, 8'd1, 4'd3, 16'd128, 8'd12, 8'd34, 8'd56, 90);
      send_gap_pct = 20;
      stall_pct = 20;
      run_phase(8'd1, 8'd255, 4'd0, 16'd511, 8'd200, 8'd100, 8'd50, 90);
      send_gap_pct = 10;
      stall_pct = 30;
      run_phase(8'd128, 8'd128, 4'd15, 16'd1, 8'd255, 8'd255, 8'd255, 110);
   endtask

   // zero width, then zero height: all reads border, writes dropped
   task automatic test_empty_image();
      send_gap_pct = 15;
      stall_pct = 15;
      run_phase(8'd0, 8'd9, 4'd4, 16'd256, 8'd1, 8'd2, 8'd3, 40);
      run_phase(8'd9, 8'd0, 4'd2, 16'd256, 8'd254, 8'd253, 8'd252, 30);
   endtask

   // back-to-back traffic with no random gaps or stalls on either side
   task automatic test_quiet_tail();
      send_gap_pct = 0;
      stall_pct = 0;
      run_phase(8'd7, 8'd5, 4'd3, 16'd384, 8'd255, 8'd255, 8'd255, 160);
   endtask

   // receiver stall bursts
   always begin
      @(negedge clock);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(string name, logic [7:0] want, got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // compare each returned pixel with the oldest prediction
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual %h", $time,
                     {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha});
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("red", want.red, rsp_out_red);
            check_field("green", want.green, rsp_out_green);
            check_field("blue", want.blue, rsp_out_blue);
            check_field("alpha", want.alpha, rsp_out_alpha);
         end
      end
   end

   initial begin
      cfg_shadow = {isor_pkg::RST_IMAGE_WIDTH, isor_pkg::RST_IMAGE_HEIGHT,
                    isor_pkg::RST_BORDER_SIZE, isor_pkg::RST_GAIN_Q8,
                    isor_pkg::RST_FILL_RED, isor_pkg::RST_FILL_GREEN,
                    isor_pkg::RST_FILL_BLUE};
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_gain_and_neighbors();
      test_resize_reuse();
      test_random_sizes();
      test_empty_image();
      test_quiet_tail();
      wait_idle();
      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // hang guard
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
`default_nettype wire
